@@ sv/ydh_pkg.sv @@
// shared types, constants and the factorial table for the hook-length dimension block
package ydh_pkg;

    localparam int ROW_W   = 5;
    localparam int SUM_W   = 9;
    localparam int PROD_W  = 62;
    localparam int DIM_W   = 32;
    localparam int STAT_W  = 2;
    localparam int NCFG_W  = 5;
    localparam int APB_AW  = 2;
    localparam int APB_DW  = 32;

    localparam logic [SUM_W-1:0]  SUM_LIMIT = 9'd511;
    localparam logic [APB_AW-1:0] ADDR_TOTAL_CELLS = 2'd0;

    typedef logic [STAT_W-1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_RISE = 2'd1;
    localparam status_t ST_SUM  = 2'd2;
    localparam status_t ST_ROWS = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_CELL,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [PROD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [PROD_W-1:0] factorial(input logic [NCFG_W-1:0] k);
        logic [PROD_W-1:0] f;
        case (k)
            5'd0:    f = 62'd1;
            5'd1:    f = 62'd1;
            5'd2:    f = 62'd2;
            5'd3:    f = 62'd6;
            5'd4:    f = 62'd24;
            5'd5:    f = 62'd120;
            5'd6:    f = 62'd720;
            5'd7:    f = 62'd5040;
            5'd8:    f = 62'd40320;
            5'd9:    f = 62'd362880;
            5'd10:   f = 62'd3628800;
            5'd11:   f = 62'd39916800;
            5'd12:   f = 62'd479001600;
            5'd13:   f = 62'd6227020800;
            5'd14:   f = 62'd87178291200;
            5'd15:   f = 62'd1307674368000;
            5'd16:   f = 62'd20922789888000;
            5'd17:   f = 62'd355687428096000;
            5'd18:   f = 62'd6402373705728000;
            5'd19:   f = 62'd121645100408832000;
            5'd20:   f = 62'd2432902008176640000;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

@@ sv/ydh_channels.sv @@
// valid/ready channel interfaces for row input and result output
interface ydh_row_if;
    logic                     valid;
    logic                     ready;
    logic [ydh_pkg::ROW_W-1:0] row_length;
    logic                     last_row;

    modport source (output valid, output row_length, output last_row, input ready);
    modport sink   (input valid, input row_length, input last_row, output ready);
endinterface

interface ydh_result_if;
    logic                       valid;
    logic                       ready;
    logic [ydh_pkg::DIM_W-1:0]  dimension;
    logic [ydh_pkg::PROD_W-1:0] hook_product;
    logic [ydh_pkg::STAT_W-1:0] status;

    modport source (output valid, output dimension, output hook_product, output status,
                    input ready);
    modport sink   (input valid, input dimension, input hook_product, input status,
                    output ready);
endinterface

@@ sv/ydh_cfg.sv @@
// apb register file holding total_cells
module ydh_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ydh_pkg::APB_AW-1:0]   paddr,
    input  logic [ydh_pkg::APB_DW-1:0]   pwdata,
    output logic [ydh_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output logic [ydh_pkg::NCFG_W-1:0]   total_cells
);
    import ydh_pkg::*;

    logic [NCFG_W-1:0] total_cells_reg;
    logic [NCFG_W-1:0] total_cells_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_TOTAL_CELLS);

    always_comb
    begin
        total_cells_next = total_cells_reg;
        if (wr_en)
        begin
            total_cells_next = pwdata[NCFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_cells_reg <= 5'd1;
        end
        else
        begin
            total_cells_reg <= total_cells_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_TOTAL_CELLS)
        begin
            prdata = {{(APB_DW-NCFG_W){1'b0}}, total_cells_reg};
        end
    end

    assign total_cells = total_cells_reg;

endmodule

@@ sv/ydh_row_store.sv @@
// synchronous row-length memory, one write and one registered read port
module ydh_row_store #(
    parameter int DEPTH = 20,
    parameter int AW    = 5
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [ydh_pkg::ROW_W-1:0]  wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [ydh_pkg::ROW_W-1:0]  rdata
);
    import ydh_pkg::*;

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/ydh_divider.sv @@
// restoring divider, one quotient bit per cycle
module ydh_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  ydh_pkg::div_req_t   req,
    output ydh_pkg::div_rsp_t   rsp
);
    import ydh_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [PROD_W-1:0] dvs_reg, dvs_next;
    logic [PROD_W:0]   rem_sh;
    logic [PROD_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[PROD_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = CNT_W'(PROD_W);
            rem_next   = '0;
            quo_next   = req.dividend;
            dvs_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sub[PROD_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[PROD_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ sv/young_diagram_hook_dimension.sv @@
// top level: hook-length formula dimension of a young diagram
//
// rows channel: one row length per transaction, top row first, last_row on the
// final row. rows are taken whenever the block is loading.
// result channel: one transaction per diagram, carrying dimension, hook_product
// and status; error results carry zero dimension and product.
// apb byte address 0 holds total_cells; the user writes it only while idle, unchecked.
// after the final row the block walks the row memory: a read state plus an end state
// per stored row and a multiply state per cell, then a 62-step restoring divider
// forms n!/product; an error result goes from its final row straight to the done
// state. the time per diagram is set by the row memory's single read port and the
// one-bit-per-cycle divider.
// rows are not accepted during the walk and divide.
// the result sits in an output register; a stalled receiver holds it there,
// and loading of the next diagram goes on until its result needs the register.
// reset clears the diagram state and the output valid; total_cells resets to 1.
// the row memory needs no clearing, only written rows are ever read.
module young_diagram_hook_dimension #(
    parameter int MAX_CELLS = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    ydh_row_if.sink                      rows,
    ydh_result_if.source                 result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ydh_pkg::APB_AW-1:0]   paddr,
    input  logic [ydh_pkg::APB_DW-1:0]   pwdata,
    output logic [ydh_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import ydh_pkg::*;

    localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CNT_W = $clog2(MAX_CELLS + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   rows_cnt_reg, rows_cnt_next;
    logic [SUM_W-1:0]   cell_sum_reg, cell_sum_next;
    status_t            order_err_reg, order_err_next;
    logic [ROW_W-1:0]   prev_len_reg, prev_len_next;
    logic [CNT_W-1:0]   col_reg [MAX_CELLS];
    logic [CNT_W-1:0]   col_next [MAX_CELLS];
    logic [CNT_W-1:0]   walk_r_reg, walk_r_next;
    logic [ROW_W-1:0]   walk_c_reg, walk_c_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    status_t            status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    logic [DIM_W-1:0]   out_dim_reg, out_dim_next;
    logic [PROD_W-1:0]  out_prod_reg, out_prod_next;
    status_t            out_status_reg, out_status_next;

    logic [NCFG_W-1:0]  total_cells;
    logic               in_fire;
    logic               full;
    logic               row_we;
    logic               row_re;
    logic [ROW_W-1:0]   row_rdata;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_upd;
    status_t            err_upd;
    status_t            status_dec;
    logic               out_free;
    logic [7:0]         hook_wide;
    logic [ROW_W-1:0]   hook;
    logic [PROD_W+ROW_W-1:0] prod_mul;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    ydh_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .total_cells (total_cells)
    );

    ydh_row_store #(
        .DEPTH (MAX_CELLS),
        .AW    (AW)
    ) u_rows (
        .clk   (clk),
        .we    (row_we),
        .waddr (rows_cnt_reg[AW-1:0]),
        .wdata (rows.row_length),
        .re    (row_re),
        .raddr (walk_r_reg[AW-1:0]),
        .rdata (row_rdata)
    );

    ydh_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign rows.ready = (state_reg == S_IDLE);
    assign in_fire    = rows.valid && rows.ready;
    assign full       = (rows_cnt_reg == CNT_W'(MAX_CELLS));
    assign row_we     = in_fire && !full;
    assign row_re     = (state_reg == S_WALK_RD) && (walk_r_reg != rows_cnt_reg);
    assign out_free   = !out_valid_reg || result.ready;

    assign sum_wide = {1'b0, cell_sum_reg} + (SUM_W+1)'(rows.row_length);
    assign sum_upd  = (sum_wide > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : sum_wide[SUM_W-1:0];

    always_comb
    begin
        err_upd = order_err_reg;
        if (order_err_reg == ST_OK)
        begin
            if (full)
            begin
                err_upd = ST_ROWS;
            end
            else if ((rows_cnt_reg != '0) && (rows.row_length > prev_len_reg))
            begin
                err_upd = ST_RISE;
            end
        end
    end

    always_comb
    begin
        if (err_upd != ST_OK)
        begin
            status_dec = err_upd;
        end
        else if ((sum_upd != SUM_W'(total_cells)) || (total_cells > NCFG_W'(MAX_CELLS)))
        begin
            status_dec = ST_SUM;
        end
        else
        begin
            status_dec = ST_OK;
        end
    end

    // arm plus leg plus one, legs from the running column heights
    assign hook_wide = 8'(row_rdata) - 8'(walk_c_reg) + 8'(col_reg[walk_c_reg[AW-1:0]])
                     - 8'(walk_r_reg) - 8'd1;
    assign hook      = hook_wide[ROW_W-1:0];
    assign prod_mul  = {{ROW_W{1'b0}}, prod_reg} * (PROD_W+ROW_W)'(hook);

    assign div_req.start    = (state_reg == S_DIV_START);
    assign div_req.dividend = factorial(total_cells);
    assign div_req.divisor  = prod_reg;

    always_comb
    begin
        state_next      = state_reg;
        rows_cnt_next   = rows_cnt_reg;
        cell_sum_next   = cell_sum_reg;
        order_err_next  = order_err_reg;
        prev_len_next   = prev_len_reg;
        col_next        = col_reg;
        walk_r_next     = walk_r_reg;
        walk_c_next     = walk_c_reg;
        prod_next       = prod_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_dim_next    = out_dim_reg;
        out_prod_next   = out_prod_reg;
        out_status_next = out_status_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cell_sum_next  = sum_upd;
                    order_err_next = err_upd;
                    if (!full)
                    begin
                        rows_cnt_next = rows_cnt_reg + CNT_W'(1);
                        prev_len_next = rows.row_length;
                        for (int c = 0; c < MAX_CELLS; c++)
                        begin
                            if (ROW_W'(c) < rows.row_length)
                            begin
                                col_next[c] = col_reg[c] + CNT_W'(1);
                            end
                        end
                    end
                    if (rows.last_row)
                    begin
                        status_next = status_dec;
                        walk_r_next = '0;
                        walk_c_next = '0;
                        prod_next   = PROD_W'(1);
                        state_next  = (status_dec == ST_OK) ? S_WALK_RD : S_DONE;
                    end
                end
            end
            S_WALK_RD:
            begin
                walk_c_next = '0;
                if (walk_r_reg == rows_cnt_reg)
                begin
                    state_next = S_DIV_START;
                end
                else
                begin
                    state_next = S_WALK_CELL;
                end
            end
            S_WALK_CELL:
            begin
                if (walk_c_reg >= row_rdata)
                begin
                    walk_r_next = walk_r_reg + CNT_W'(1);
                    state_next  = S_WALK_RD;
                end
                else
                begin
                    prod_next   = prod_mul[PROD_W-1:0];
                    walk_c_next = walk_c_reg + ROW_W'(1);
                end
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    if (status_reg == ST_OK)
                    begin
                        out_dim_next  = div_rsp.quotient[DIM_W-1:0];
                        out_prod_next = prod_reg;
                    end
                    else
                    begin
                        out_dim_next  = '0;
                        out_prod_next = '0;
                    end
                    rows_cnt_next  = '0;
                    cell_sum_next  = '0;
                    order_err_next = ST_OK;
                    for (int c = 0; c < MAX_CELLS; c++)
                    begin
                        col_next[c] = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cnt_reg  <= '0;
            cell_sum_reg  <= '0;
            order_err_reg <= ST_OK;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < MAX_CELLS; c++)
            begin
                col_reg[c] <= '0;
            end
        end
        else
        begin
            rows_cnt_reg  <= rows_cnt_next;
            cell_sum_reg  <= cell_sum_next;
            order_err_reg <= order_err_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_len_reg   <= prev_len_next;
        walk_r_reg     <= walk_r_next;
        walk_c_reg     <= walk_c_next;
        prod_reg       <= prod_next;
        status_reg     <= status_next;
        out_dim_reg    <= out_dim_next;
        out_prod_reg   <= out_prod_next;
        out_status_reg <= out_status_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.dimension    = out_dim_reg;
    assign result.hook_product = out_prod_reg;
    assign result.status       = out_status_reg;

`ifndef SYNTH
    a_store_only_loading: assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> (state_reg == S_IDLE))
        else $error("row memory written outside loading");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result loaded outside done state");

    a_ok_nonzero_product: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_OK)) |-> (out_prod_reg != '0))
        else $error("ok result with zero hook product");

    a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK))
            |-> ((out_dim_reg == '0) && (out_prod_reg == '0)))
        else $error("error result with nonzero payload");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");
`endif

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for the young diagram hook-length dimension block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ydh_pkg::*;

    localparam int MAX_ROWS     = 20;
    localparam int CELL_SUM_CAP = 511;
    localparam int RANDOM_ROWS  = 1200;
    localparam int DRAIN_CYCLES = 150;

    typedef logic [ROW_W-1:0] row_len_t;

    typedef struct {
        logic [DIM_W-1:0]  dimension;
        logic [PROD_W-1:0] hook_product;
        status_t           status;
    } hook_result_t;

    // shadow of the diagram state, predicts one result per final row
    class hook_dim_scoreboard;
        row_len_t          row_mem [MAX_ROWS];
        int unsigned       rows_cnt;
        int unsigned       cell_sum;
        status_t           first_err;
        logic [NCFG_W-1:0] cells_cfg;
        logic [63:0]       fact [21];
        hook_result_t      pending_results [$];
        int                errors;

        function new();
            fact[0] = 64'd1;
            for (int k = 1; k <= 20; k++)
                fact[k] = fact[k-1] * 64'(k);
            cells_cfg = 5'd1;
            rows_cnt  = 0;
            cell_sum  = 0;
            first_err = ST_OK;
            errors    = 0;
        endfunction

        task report(input string msg);
            errors++;
            $display("tb_top: mismatch: %s", msg);
        endtask

        function int unsigned row_at(input int unsigned r);
            if (r < rows_cnt)
                return 32'(row_mem[r]);
            return 0;
        endfunction

        function logic [63:0] hook_walk();
            logic [63:0] prod;
            int unsigned len;
            int unsigned hook;
            prod = 64'd1;
            for (int r = 0; r < rows_cnt; r++)
            begin
                len = 32'(row_mem[r]);
                for (int c = 0; c < len; c++)
                begin
                    hook = len - c;
                    // leg: rows below that still reach this column
                    for (int b = r + 1; b < MAX_ROWS && c < row_at(b); b++)
                        hook++;
                    prod = prod * 64'(hook);
                end
            end
            return prod;
        endfunction

        function void note_row(input row_len_t len, input logic is_last);
            hook_result_t e;
            logic [63:0]  prod;
            if (rows_cnt >= MAX_ROWS)
            begin
                if (first_err == ST_OK)
                    first_err = ST_ROWS;
            end
            else
            begin
                if (rows_cnt > 0 && len > row_mem[rows_cnt-1] && first_err == ST_OK)
                    first_err = ST_RISE;
                row_mem[rows_cnt] = len;
                rows_cnt++;
            end
            cell_sum = cell_sum + 32'(len);
            if (cell_sum > CELL_SUM_CAP)
                cell_sum = CELL_SUM_CAP;
            if (!is_last)
                return;

            e.dimension    = '0;
            e.hook_product = '0;
            if (first_err != ST_OK)
                e.status = first_err;
            else if (cell_sum != 32'(cells_cfg) || cells_cfg > MAX_ROWS)
                e.status = ST_SUM;
            else
            begin
                e.status = ST_OK;
                prod = hook_walk();
                if (prod == 0)
                    prod = 64'd1;
                e.hook_product = prod[PROD_W-1:0];
                e.dimension    = DIM_W'(fact[cells_cfg] / prod);
            end
            pending_results.push_back(e);
            rows_cnt  = 0;
            cell_sum  = 0;
            first_err = ST_OK;
        endfunction

        task check_result(input logic [DIM_W-1:0] dim, input logic [PROD_W-1:0] prod,
                          input status_t st);
            hook_result_t e;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result with nothing pending: dim %0d prod %0d status %0d",
                                 dim, prod, st));
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.status)
                report($sformatf("status %0d, predicted %0d", st, e.status));
            if (dim !== e.dimension)
                report($sformatf("dimension %0d, predicted %0d", dim, e.dimension));
            if (prod !== e.hook_product)
                report($sformatf("hook_product %0d, predicted %0d", prod, e.hook_product));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    ydh_row_if    rows_if ();
    ydh_result_if result_if ();

    young_diagram_hook_dimension i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rows    (rows_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hook_dim_scoreboard sb = new();
    row_len_t           shape [$];
    int                 rows_sent = 0;
    bit                 src_steady = 1'b0;
    bit                 sink_steady = 1'b0;
    int                 stall_left = 0;
    int                 sink_pick;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // gap before the next row: mostly none or short, a few long, some bursts
    function automatic int pick_gap();
        int p;
        if ($urandom_range(0, 199) == 0)
            src_steady = !src_steady;
        if (src_steady)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task send_row(input row_len_t len, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rows_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rows_if.valid      <= 1'b1;
        rows_if.row_length <= len;
        rows_if.last_row   <= is_last;
        do
            @(posedge clk);
        while (!rows_if.ready);
        sb.note_row(len, is_last);
        rows_sent++;
    endtask

    task send_shape();
        for (int i = 0; i < shape.size(); i++)
            send_row(shape[i], i == shape.size() - 1);
    endtask

    task wait_idle();
        rows_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb write of total_cells, then read it back
    task set_cells(input logic [NCFG_W-1:0] n);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TOTAL_CELLS;
        pwdata  <= {(APB_DW-NCFG_W)'($urandom()), n};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.cells_cfg = n;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[NCFG_W-1:0] !== n)
            sb.report($sformatf("total_cells reads %0d, written %0d", prdata[NCFG_W-1:0], n));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // non-increasing rows summing to n
    task build_partition(input int n);
        int rem;
        int prev;
        int hi;
        int l;
        shape.delete();
        if (n == 0)
            shape.push_back('0);
        rem  = n;
        prev = MAX_ROWS;
        while (rem > 0)
        begin
            hi = (prev < rem) ? prev : rem;
            l  = $urandom_range(1, hi);
            shape.push_back(row_len_t'(l));
            prev = l;
            rem  = rem - l;
        end
    endtask

    task build_random_shape();
        int kind;
        int idx;
        kind = $urandom_range(0, 99);
        shape.delete();
        if (kind < 72)
        begin
            build_partition(int'(sb.cells_cfg));
            // trailing empty rows are legal
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) shape.push_back('0);
        end
        else if (kind < 80)
        begin
            build_partition(int'(sb.cells_cfg));
            idx = $urandom_range(0, shape.size() - 1);
            if ($urandom_range(0, 1) == 1 && shape[idx] != 0)
                shape[idx] = shape[idx] - row_len_t'(1);
            else if (shape[idx] < MAX_ROWS)
                shape[idx] = shape[idx] + row_len_t'(1);
        end
        else if (kind < 87)
            build_partition($urandom_range(0, 20));
        else if (kind < 93)
        begin
            repeat ($urandom_range(1, 8)) shape.push_back(row_len_t'($urandom_range(0, 20)));
        end
        else if (kind < 97)
        begin
            // overflow the row store, often driving the cell sum into saturation
            repeat ($urandom_range(21, 28))
                shape.push_back(($urandom_range(0, 1) == 1) ? row_len_t'(20)
                                                            : row_len_t'($urandom_range(0, 20)));
        end
        else
        begin
            repeat ($urandom_range(19, 21)) shape.push_back(row_len_t'(1));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
                sb.check_result(result_if.dimension, result_if.hook_product, result_if.status);
            if ($urandom_range(0, 299) == 0)
                sink_steady = !sink_steady;
            if (stall_left > 0)
            begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_if.ready <= 1'b1;
                if (!sink_steady)
                begin
                    sink_pick = $urandom_range(0, 99);
                    if (sink_pick < 20)
                        stall_left = $urandom_range(1, 3);
                    else if (sink_pick < 24)
                        stall_left = $urandom_range(8, 40);
                end
            end
        end
    end

    initial
    begin
        #8000000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        int p;
        logic [NCFG_W-1:0] n;
        rst_n              = 1'b0;
        rows_if.valid      = 1'b0;
        rows_if.row_length = '0;
        rows_if.last_row   = 1'b0;
        result_if.ready    = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // total_cells still at its reset value of one
        shape = '{row_len_t'(1)};
        send_shape();
        shape = '{row_len_t'(0), row_len_t'(1)};
        send_shape();
        // empty diagram
        set_cells(5'd0);
        shape = '{row_len_t'(0)};
        send_shape();
        // n above the table always mismatches
        set_cells(5'd31);
        shape = '{row_len_t'(20), row_len_t'(11)};
        send_shape();
        set_cells(5'd20);
        shape = '{row_len_t'(20)};
        send_shape();
        shape = '{row_len_t'(5), row_len_t'(5), row_len_t'(5), row_len_t'(5)};
        send_shape();
        shape = '{row_len_t'(10), row_len_t'(9)};
        send_shape();
        shape = '{row_len_t'(16), row_len_t'(4)};
        send_shape();
        shape = '{row_len_t'(8), row_len_t'(8), row_len_t'(4)};
        send_shape();

        rows_sent = 0;
        while (rows_sent < RANDOM_ROWS)
        begin
            p = $urandom_range(0, 99);
            if (p < 6)
                n = 5'd0;
            else if (p < 12)
                n = NCFG_W'($urandom_range(21, 31));
            else if (p < 25)
                n = 5'd20;
            else if (p < 32)
                n = 5'd1;
            else
                n = NCFG_W'($urandom_range(1, 20));
            set_cells(n);
            repeat ($urandom_range(10, 30))
            begin
                build_random_shape();
                send_shape();
            end
        end

        wait_idle();
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

@@ sim.f @@
sv/ydh_pkg.sv
sv/ydh_channels.sv
sv/ydh_cfg.sv
sv/ydh_row_store.sv
sv/ydh_divider.sv
sv/young_diagram_hook_dimension.sv
dv/tb_top.sv
